// ===== rtl/core/qvr_pkg.sv =====
// Shared types and constants for the quaternion vector rotation block.
// Used by every module under rtl/core; depends on nothing else.
package qvr_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int Q_BITS         = 16;
    localparam int Q_FRAC         = 14;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic signed [Q_BITS-1:0] Q_W_RESET = 16'sd16384;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_QUAT_W = 3'd0,
        CFG_QUAT_X = 3'd1,
        CFG_QUAT_Y = 3'd2,
        CFG_QUAT_Z = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [Q_BITS-1:0] w;
        logic signed [Q_BITS-1:0] x;
        logic signed [Q_BITS-1:0] y;
        logic signed [Q_BITS-1:0] z;
    } t_quat;

    // Load enables of a two-register arithmetic section.
    typedef struct packed {
        logic en_a;
        logic en_b;
    } t_stg_ctl;

endpackage

// ===== rtl/core/qvr_cfg.sv =====
// Quaternion register file written through the configuration channel.
// Depends on qvr_pkg.
module qvr_cfg import qvr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_index,
    input  logic [CFG_DATA_BITS-1:0] i_data,
    output t_quat                    o_quat
);

    t_quat r_quat;
    t_quat n_quat;

    assign o_ready = 1'b1;
    assign o_quat  = r_quat;

    always_comb begin
        n_quat = r_quat;
        if (i_valid) begin
            case (t_cfg_idx'(i_index))
                CFG_QUAT_W: n_quat.w = i_data;
                CFG_QUAT_X: n_quat.x = i_data;
                CFG_QUAT_Y: n_quat.y = i_data;
                CFG_QUAT_Z: n_quat.z = i_data;
                default:    n_quat = r_quat;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat <= '{w: Q_W_RESET, x: '0, y: '0, z: '0};
        end else begin
            r_quat <= n_quat;
        end
    end

endmodule

// ===== rtl/core/qvr_cross.sv =====
// Two-register cross product q x v with Q2.14 rounding to nearest.
// Depends on qvr_pkg.
module qvr_cross import qvr_pkg::*; #(
    parameter int IN_BITS = COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  t_stg_ctl                  i_ctl,
    input  t_quat                     i_q,
    input  logic signed [IN_BITS-1:0] i_v [3],
    output logic signed [IN_BITS+2:0] o_r [3]
);

    localparam int P = Q_BITS + IN_BITS;
    localparam logic signed [P:0] RND = (P+1)'(2 ** (Q_FRAC - 1));

    logic signed [P-1:0]     r_pa [3];
    logic signed [P-1:0]     r_pb [3];
    logic signed [P-1:0]     n_pa [3];
    logic signed [P-1:0]     n_pb [3];
    logic signed [P:0]       diff [3];
    logic signed [IN_BITS+2:0] r_r [3];
    logic signed [IN_BITS+2:0] n_r [3];

    always_comb begin
        n_pa[0] = i_q.y * i_v[2];
        n_pb[0] = i_q.z * i_v[1];
        n_pa[1] = i_q.z * i_v[0];
        n_pb[1] = i_q.x * i_v[2];
        n_pa[2] = i_q.x * i_v[1];
        n_pb[2] = i_q.y * i_v[0];
    end

    // Adding half an LSB and dropping the fraction rounds halves upward.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k] = r_pa[k] - r_pb[k] + RND;
            n_r[k]  = diff[k][P:Q_FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_a) begin
            r_pa <= n_pa;
            r_pb <= n_pb;
        end
        if (i_ctl.en_b) begin
            r_r <= n_r;
        end
    end

    assign o_r = r_r;

endmodule

// ===== rtl/core/qvr_scale.sv =====
// Two-register scaling of a vector by the Q2.14 scalar part, rounded.
// Depends on qvr_pkg.
module qvr_scale import qvr_pkg::*; #(
    parameter int IN_BITS = COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  t_stg_ctl                  i_ctl,
    input  logic signed [Q_BITS-1:0]  i_w,
    input  logic signed [IN_BITS-1:0] i_v [3],
    output logic signed [IN_BITS+2:0] o_r [3]
);

    localparam int P = Q_BITS + IN_BITS;
    localparam logic signed [P:0] RND = (P+1)'(2 ** (Q_FRAC - 1));

    logic signed [P-1:0]       r_p [3];
    logic signed [P-1:0]       n_p [3];
    logic signed [P:0]         rsum [3];
    logic signed [IN_BITS+2:0] r_r [3];
    logic signed [IN_BITS+2:0] n_r [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_p[k]  = i_w * i_v[k];
            rsum[k] = r_p[k] + RND;
            n_r[k]  = rsum[k][P:Q_FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_a) begin
            r_p <= n_p;
        end
        if (i_ctl.en_b) begin
            r_r <= n_r;
        end
    end

    assign o_r = r_r;

endmodule

// ===== rtl/core/qvr_sat.sv =====
// Final three-term sum per component, clipped to the coordinate range,
// held in the output register. Depends on qvr_pkg.
module qvr_sat import qvr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [COORD_BITS-1:0] i_v [3],
    input  logic signed [COORD_BITS+6:0] i_a [3],
    input  logic signed [COORD_BITS+6:0] i_b [3],
    output logic signed [COORD_BITS-1:0] o_r [3],
    output logic                         o_sat
);

    localparam int S = COORD_BITS + 9;
    localparam logic signed [S-1:0] MAXV = {{(S-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [S-1:0] MINV = {{(S-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

    logic signed [S-1:0]          sum  [3];
    logic signed [COORD_BITS-1:0] n_r  [3];
    logic signed [COORD_BITS-1:0] r_r  [3];
    logic [2:0]                   clip;
    logic                         r_sat;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum[k]  = i_v[k] + i_a[k] + i_b[k];
            clip[k] = 1'b1;
            if (sum[k] > MAXV) begin
                n_r[k] = MAXV[COORD_BITS-1:0];
            end else if (sum[k] < MINV) begin
                n_r[k] = MINV[COORD_BITS-1:0];
            end else begin
                n_r[k]  = sum[k][COORD_BITS-1:0];
                clip[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r   <= n_r;
            r_sat <= |clip;
        end
    end

    assign o_r   = r_r;
    assign o_sat = r_sat;

endmodule

// ===== rtl/core/quaternion_vector_rotate.sv =====
// Top level of the quaternion vector rotation block: v' = v + w*t + q x t,
// t = 2*(q x v). Depends on qvr_pkg, qvr_cfg, qvr_cross, qvr_scale, qvr_sat.
//
//   Channel  Handshake                  Payload
//   cfg      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data (Q2.14)
//   in       i_in_valid  / o_in_ready   i_in_x, i_in_y, i_in_z
//   out      o_out_valid / i_out_ready  o_out_x, o_out_y, o_out_z, o_out_saturated
//
// Five register stages: first products, first cross product, second products,
// rounded terms, and the clipped sum in the output register. One item is taken
// every cycle unless a stalled output has backed the pipeline up to the input.
// Each stage loads when it is empty or the stage after it moves, so a stalled
// output keeps its item while the earlier stages keep filling their bubbles.
// Synchronous reset empties the pipeline and loads the identity quaternion.
module quaternion_vector_rotate import qvr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [COORD_BITS-1:0] i_in_x,
    input  logic signed [COORD_BITS-1:0] i_in_y,
    input  logic signed [COORD_BITS-1:0] i_in_z,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [COORD_BITS-1:0] o_out_x,
    output logic signed [COORD_BITS-1:0] o_out_y,
    output logic signed [COORD_BITS-1:0] o_out_z,
    output logic                         o_out_saturated
);

    localparam int NSTG = 5;
    localparam int TB   = COORD_BITS + 4;

    t_quat                        quat;
    logic [NSTG-1:0]              r_vld;
    logic [NSTG-1:0]              n_vld;
    logic [NSTG-1:0]              en;
    logic signed [COORD_BITS-1:0] vin  [3];
    logic signed [COORD_BITS-1:0] r_v0 [3];
    logic signed [COORD_BITS-1:0] r_v1 [3];
    logic signed [COORD_BITS-1:0] r_v2 [3];
    logic signed [COORD_BITS-1:0] r_v3 [3];
    logic signed [COORD_BITS+2:0] t1   [3];
    logic signed [TB-1:0]         t2   [3];
    logic signed [TB+2:0]         u    [3];
    logic signed [TB+2:0]         wt   [3];
    logic signed [COORD_BITS-1:0] res  [3];
    t_stg_ctl                     ctl1;
    t_stg_ctl                     ctl2;

    qvr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .o_ready (o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_quat  (quat)
    );

    // Stall chain: a stage takes a new item when it is empty or drains.
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld[0] = en[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = en[0];
    assign o_out_valid = r_vld[NSTG-1];

    assign vin[0] = i_in_x;
    assign vin[1] = i_in_y;
    assign vin[2] = i_in_z;

    // The input vector rides alongside the arithmetic until the final sum.
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_v0 <= vin;
        end
        if (en[1]) begin
            r_v1 <= r_v0;
        end
        if (en[2]) begin
            r_v2 <= r_v1;
        end
        if (en[3]) begin
            r_v3 <= r_v2;
        end
    end

    assign ctl1 = '{en_a: en[0], en_b: en[1]};
    assign ctl2 = '{en_a: en[2], en_b: en[3]};

    qvr_cross #(.IN_BITS(COORD_BITS)) u_cross1 (
        .i_clk (i_clk),
        .i_ctl (ctl1),
        .i_q   (quat),
        .i_v   (vin),
        .o_r   (t1)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            t2[k] = $signed({t1[k], 1'b0});
        end
    end

    qvr_cross #(.IN_BITS(TB)) u_cross2 (
        .i_clk (i_clk),
        .i_ctl (ctl2),
        .i_q   (quat),
        .i_v   (t2),
        .o_r   (u)
    );

    qvr_scale #(.IN_BITS(TB)) u_scale (
        .i_clk (i_clk),
        .i_ctl (ctl2),
        .i_w   (quat.w),
        .i_v   (t2),
        .o_r   (wt)
    );

    qvr_sat #(.COORD_BITS(COORD_BITS)) u_sat (
        .i_clk (i_clk),
        .i_en  (en[NSTG-1]),
        .i_v   (r_v3),
        .i_a   (wt),
        .i_b   (u),
        .o_r   (res),
        .o_sat (o_out_saturated)
    );

    assign o_out_x = res[0];
    assign o_out_y = res[1];
    assign o_out_z = res[2];

    localparam logic [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && !en[2]) |=> r_vld[2])
        else $error("stalled stage lost its item");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while the pipeline is full and stalled");

    a_entry_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_vld[0]) |-> $past(i_in_valid && o_in_ready))
        else $error("first stage filled without an accepted item");

    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_saturated) |->
            (o_out_x == CMAX || o_out_x == CMIN || o_out_y == CMAX ||
             o_out_y == CMIN || o_out_z == CMAX || o_out_z == CMIN))
        else $error("saturation flag without a clipped component");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for quaternion_vector_rotate: streams vectors through
// the block under several quaternion settings and compares every rotated item.
// Depends on qvr_pkg and the RTL under rtl/core.
module testbench;
    import qvr_pkg::*;

    localparam int CW             = COORD_BITS_DEF;
    localparam int CLK_PERIOD     = 8;
    localparam int PIPE_LAT       = 5;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int PRESSURE_PHASE = 3;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_PRINTED    = 100;

    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 sat;
    } t_rot;

    typedef struct packed {
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] data;
    } t_reg_write;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]     i_cfg_data = '0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic signed [CW-1:0]         i_in_x = '0;
    logic signed [CW-1:0]         i_in_y = '0;
    logic signed [CW-1:0]         i_in_z = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic signed [CW-1:0]         o_out_x;
    logic signed [CW-1:0]         o_out_y;
    logic signed [CW-1:0]         o_out_z;
    logic                         o_out_saturated;

    // Local copy of the quaternion registers.
    logic signed [Q_BITS-1:0] quat_w = Q_W_RESET;
    logic signed [Q_BITS-1:0] quat_x = '0;
    logic signed [Q_BITS-1:0] quat_y = '0;
    logic signed [Q_BITS-1:0] quat_z = '0;

    t_vec       vec_pending[$];
    t_rot       rot_expected[$];
    t_reg_write reg_writes[$];

    logic       cfg_fire = 1'b0;
    logic       in_fire = 1'b0;
    logic       rx_hold = 1'b0;
    int         tx_gap = 0;
    int         rx_stall = 0;
    int         tx_mode = 0;
    int         rx_mode = 0;
    int         phase_id = 0;
    int         errors = 0;
    int         n_results = 0;
    t_vec       next_vec;
    t_reg_write next_write;
    t_rot       got;
    t_rot       want;

    quaternion_vector_rotate #(
        .COORD_BITS(CW)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_x         (i_in_x),
        .i_in_y         (i_in_y),
        .i_in_z         (i_in_z),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_z        (o_out_z),
        .o_out_saturated(o_out_saturated)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // Divide by 2^14, rounding to nearest with halves toward plus infinity.
    function automatic longint round_q14(longint num);
        return (num + (longint'(1) <<< (Q_FRAC - 1))) >>> Q_FRAC;
    endfunction

    function automatic longint cross_term(longint a, longint b, longint c, longint d);
        return round_q14(a * b - c * d);
    endfunction

    function automatic t_rot rotate_vec(t_vec v);
        longint w, qx, qy, qz, vx, vy, vz, tx, ty, tz, ux, uy, uz, hi, lo;
        longint sum[3];
        t_rot   r;
        int     i;
        w  = quat_w;
        qx = quat_x;
        qy = quat_y;
        qz = quat_z;
        vx = v.x;
        vy = v.y;
        vz = v.z;
        tx = 2 * cross_term(qy, vz, qz, vy);
        ty = 2 * cross_term(qz, vx, qx, vz);
        tz = 2 * cross_term(qx, vy, qy, vx);
        ux = cross_term(qy, tz, qz, ty);
        uy = cross_term(qz, tx, qx, tz);
        uz = cross_term(qx, ty, qy, tx);
        sum[0] = vx + round_q14(w * tx) + ux;
        sum[1] = vy + round_q14(w * ty) + uy;
        sum[2] = vz + round_q14(w * tz) + uz;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        r.sat = 1'b0;
        for (i = 0; i < 3; i++) begin
            if (sum[i] > hi) begin
                sum[i] = hi;
                r.sat = 1'b1;
            end
            if (sum[i] < lo) begin
                sum[i] = lo;
                r.sat = 1'b1;
            end
        end
        r.x = CW'(sum[0]);
        r.y = CW'(sum[1]);
        r.z = CW'(sum[2]);
        return r;
    endfunction

    task automatic report_error(string msg);
        if (errors < MAX_PRINTED)
            $display("ERROR: %s", msg);
        errors++;
    endtask

    // Most gaps are short; a few run much longer.
    function automatic int pick_idle(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (mode == 1) begin
            if (r < 75) return 0;
            if (r < 97) return $urandom_range(1, 3);
            return $urandom_range(8, 40);
        end
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0, 1, 2: return CW'($urandom);
            3, 4:    return CW'(int'($urandom_range(0, 8191)) - 4096);
            5:       return ($urandom_range(0, 1) != 0) ? C_MAX : C_MIN;
            6:       return ($urandom_range(0, 1) != 0) ? C_MAX - CW'($urandom_range(0, 255))
                                                        : C_MIN + CW'($urandom_range(0, 255));
            default: return CW'(int'($urandom_range(0, 131071)) - 65536);
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] rand_quat_part();
        case ($urandom_range(0, 3))
            0:       return CFG_DATA_BITS'($urandom);
            1, 2:    return CFG_DATA_BITS'(int'($urandom_range(0, 32768)) - 16384);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return 16'sd16384;
                    2:       return -16'sd16384;
                    default: return 16'sd11585;
                endcase
            end
        endcase
    endfunction

    // Monitor: model updates, expected results and result checks, all at the rising edge.
    always @(posedge i_clk) begin
        cfg_fire <= i_cfg_valid && o_cfg_ready;
        in_fire  <= i_in_valid && o_in_ready;
        if (!i_rst_n) begin
            quat_w = Q_W_RESET;
            quat_x = '0;
            quat_y = '0;
            quat_z = '0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got.x   = o_out_x;
                got.y   = o_out_y;
                got.z   = o_out_z;
                got.sat = o_out_saturated;
                if (rot_expected.size() == 0) begin
                    report_error($sformatf("result %0d arrived with nothing expected",
                                           n_results));
                end else begin
                    want = rot_expected.pop_front();
                    if (got.x !== want.x)
                        report_error($sformatf("result %0d x: got %0d expected %0d",
                                               n_results, got.x, want.x));
                    if (got.y !== want.y)
                        report_error($sformatf("result %0d y: got %0d expected %0d",
                                               n_results, got.y, want.y));
                    if (got.z !== want.z)
                        report_error($sformatf("result %0d z: got %0d expected %0d",
                                               n_results, got.z, want.z));
                    if (got.sat !== want.sat)
                        report_error($sformatf("result %0d saturated: got %b expected %b",
                                               n_results, got.sat, want.sat));
                end
                n_results++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_QUAT_W: quat_w = i_cfg_data;
                    CFG_QUAT_X: quat_x = i_cfg_data;
                    CFG_QUAT_Y: quat_y = i_cfg_data;
                    CFG_QUAT_Z: quat_z = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                next_vec.x = i_in_x;
                next_vec.y = i_in_y;
                next_vec.z = i_in_z;
                rot_expected.push_back(rotate_vec(next_vec));
            end
        end
    end

    // Input driver: a new item goes out only once the previous one was taken
    // and its trailing gap has run out.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (tx_gap > 0) begin
                tx_gap     <= tx_gap - 1;
                i_in_valid <= 1'b0;
            end else if (vec_pending.size() > 0) begin
                next_vec    = vec_pending.pop_front();
                i_in_x     <= next_vec.x;
                i_in_y     <= next_vec.y;
                i_in_z     <= next_vec.z;
                i_in_valid <= 1'b1;
                tx_gap     <= pick_idle(tx_mode);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_cfg_valid || cfg_fire)) begin
            if (reg_writes.size() > 0) begin
                next_write   = reg_writes.pop_front();
                i_cfg_index <= next_write.idx;
                i_cfg_data  <= next_write.data;
                i_cfg_valid <= 1'b1;
            end else begin
                i_cfg_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold) begin
            i_out_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall    <= rx_stall - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            rx_stall    <= pick_idle(rx_mode);
        end
    end

    // Long receiver hold-off so the pipeline fills and back-pressures the input.
    initial begin
        wait (phase_id == PRESSURE_PHASE);
        repeat (10) @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb: failure");
        $finish;
    end

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        reg_writes.push_back('{idx: idx, data: data});
    endtask

    // Checked at the rising edge, where the drivers' queues and valids are stable.
    task automatic settle_regs();
        while (reg_writes.size() > 0 || i_cfg_valid)
            @(posedge i_clk);
    endtask

    task automatic set_quat(logic [CFG_DATA_BITS-1:0] w, logic [CFG_DATA_BITS-1:0] x,
                            logic [CFG_DATA_BITS-1:0] y, logic [CFG_DATA_BITS-1:0] z);
        write_reg(CFG_QUAT_W, w);
        write_reg(CFG_QUAT_X, x);
        write_reg(CFG_QUAT_Y, y);
        write_reg(CFG_QUAT_Z, z);
        settle_regs();
    endtask

    task automatic push_directed();
        vec_pending.push_back('{x: '0, y: '0, z: '0});
        vec_pending.push_back('{x: C_MAX, y: C_MAX, z: C_MAX});
        vec_pending.push_back('{x: C_MIN, y: C_MIN, z: C_MIN});
        vec_pending.push_back('{x: C_MAX, y: C_MIN, z: '0});
        vec_pending.push_back('{x: 1, y: -1, z: 256});
        vec_pending.push_back('{x: -256, y: 1, z: -1});
        vec_pending.push_back('{x: C_MIN, y: C_MAX, z: C_MAX});
        vec_pending.push_back('{x: 24'h555555, y: 24'hAAAAAA, z: 24'h0F0F0F});
    endtask

    task automatic push_random(int count);
        int k;
        for (k = 0; k < count; k++)
            vec_pending.push_back('{x: rand_coord(), y: rand_coord(), z: rand_coord()});
    endtask

    // The sender waits here until every expected result has come back.
    task automatic drain();
        while (vec_pending.size() > 0 || i_in_valid || rot_expected.size() > 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(negedge i_clk);
    endtask

    initial begin
        int p;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Identity quaternion straight out of reset: outputs must equal inputs.
        phase_id = 0;
        push_directed();
        drain();

        // Extreme register values; large vectors saturate.
        phase_id = 1;
        tx_mode  = 1;
        rx_mode  = 1;
        set_quat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        push_directed();
        drain();

        // Writes to indexes past the quaternion must be ignored.
        phase_id = 2;
        tx_mode  = 2;
        rx_mode  = 2;
        set_quat(16'sd11585, '0, '0, 16'sd11585);
        write_reg(CFG_IDX_BITS'($urandom_range(CFG_QUAT_Z + 1, (1 << CFG_IDX_BITS) - 1)),
                  CFG_DATA_BITS'($urandom));
        write_reg(CFG_IDX_BITS'((1 << CFG_IDX_BITS) - 1), CFG_DATA_BITS'($urandom));
        settle_regs();
        push_directed();
        drain();

        phase_id = PRESSURE_PHASE;
        tx_mode  = 0;
        rx_mode  = 0;
        set_quat(rand_quat_part(), rand_quat_part(), rand_quat_part(), rand_quat_part());
        push_random(80);
        drain();

        for (p = PRESSURE_PHASE + 1; p < PRESSURE_PHASE + 9; p++) begin
            phase_id = p;
            tx_mode  = $urandom_range(0, 2);
            rx_mode  = $urandom_range(0, 2);
            if (p == PRESSURE_PHASE + 1)
                set_quat(16'h7FFF, '0, '0, '0);
            else if (p == PRESSURE_PHASE + 2)
                set_quat('0, '0, '0, '0);
            else if (p == PRESSURE_PHASE + 3)
                set_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
            else
                set_quat(rand_quat_part(), rand_quat_part(), rand_quat_part(),
                         rand_quat_part());
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_IDX_BITS'($urandom_range(CFG_QUAT_Z + 1,
                                                       (1 << CFG_IDX_BITS) - 1)),
                          CFG_DATA_BITS'($urandom));
                settle_regs();
            end
            push_random(65);
            drain();
        end

        repeat (4 * PIPE_LAT) @(negedge i_clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
